FILE: src/addressable_led_strip_driver_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the addressable LED strip driver
// Concurrent check helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ADDRESSABLE_LED_STRIP_DRIVER_UNIT_DEFINES_SVH
`define ADDRESSABLE_LED_STRIP_DRIVER_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define ALDU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ALDU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ALDU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ALDU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/aldu_pkg.sv
// ----------------------------------------------------------------------------
// LED strip driver package
// Shared constants, codes, structs and the color wheel function.
// ----------------------------------------------------------------------------
`default_nettype none

package aldu_pkg;

    // Pixel store geometry.
    localparam int MAX_LEDS = 256;
    localparam int PIX_AW   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W    = $clog2(MAX_LEDS + 1);
    localparam int CMP_W    = (CNT_W > 9) ? CNT_W : 9;
    localparam int PIX_W    = 24;

    // Configuration port.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register reset values.
    localparam logic [8:0]  RST_LED_COUNT   = 9'd8;
    localparam logic [7:0]  RST_HIGH0       = 8'd3;
    localparam logic [7:0]  RST_LOW0        = 8'd9;
    localparam logic [7:0]  RST_HIGH1       = 8'd9;
    localparam logic [7:0]  RST_LOW1        = 8'd3;
    localparam logic [15:0] RST_RESET_TICKS = 16'd500;

    // Color wheel segment bounds.
    localparam logic [7:0] WHEEL_SEG1 = 8'd85;
    localparam logic [7:0] WHEEL_SEG2 = 8'd170;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_CLEAR   = 3'd2,
        CMD_START   = 3'd3,
        CMD_RAINBOW = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        REG_LED_COUNT   = 3'd0,
        REG_HIGH0       = 3'd1,
        REG_LOW0        = 3'd2,
        REG_HIGH1       = 3'd3,
        REG_LOW1        = 3'd4,
        REG_RESET_TICKS = 3'd5
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_HIGH  = 4'b0010,
        PH_LOW   = 4'b0100,
        PH_LATCH = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [8:0]  led_count;
        logic [7:0]  high0_ticks;
        logic [7:0]  low0_ticks;
        logic [7:0]  high1_ticks;
        logic [7:0]  low1_ticks;
        logic [15:0] reset_ticks;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic              clr;
        logic [PIX_AW-1:0] waddr;
        logic [PIX_W-1:0]  wdata;
        logic [PIX_AW-1:0] raddr;
    } t_mem_req;

    // Color wheel value packed as G, R, B.
    function automatic logic [PIX_W-1:0] wheel_grb(input logic [7:0] p);
        logic [7:0] q;
        logic [7:0] q3;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        begin
            if (p < WHEEL_SEG1) begin
                q = p;
            end else if (p < WHEEL_SEG2) begin
                q = p - WHEEL_SEG1;
            end else begin
                q = p - WHEEL_SEG2;
            end
            q3 = 8'({2'b00, q} * 10'd3);
            if (p < WHEEL_SEG1) begin
                r = 8'd255 - q3;
                g = 8'd0;
                b = q3;
            end else if (p < WHEEL_SEG2) begin
                r = 8'd0;
                g = q3;
                b = 8'd255 - q3;
            end else begin
                r = q3;
                g = 8'd255 - q3;
                b = 8'd0;
            end
            wheel_grb = {g, r, b};
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/aldu_ifs.sv
// ----------------------------------------------------------------------------
// LED strip driver channel interfaces
// Command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface aldu_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       restart_phase;

    modport source (
        output valid, command, pixel_index, red, green, blue, restart_phase,
        input  ready
    );
    modport sink (
        input  valid, command, pixel_index, red, green, blue, restart_phase,
        output ready
    );
endinterface

interface aldu_res_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic rejected;

    modport source (
        output valid, line_level, busy_res, frame_done, rejected,
        input  ready
    );
    modport sink (
        input  valid, line_level, busy_res, frame_done, rejected,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/addressable_led_strip_driver_unit.sv
// ----------------------------------------------------------------------------
// Addressable LED strip driver
// Pixel store plus one-wire frame sequencer for WS2812-style LED chains.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on i_cmd (valid/ready); each accepted beat gives exactly one
// result beat on o_res, held in an output register and shown in the cycle after
// acceptance. A tick beat advances the line by one tick and the result carries
// the line level for that tick, so the line follows the tick beats.
// Tick, write, clear and start beats are taken one per cycle. A rainbow beat
// is followed by a fill of led_count pixels (saturated to the store depth), one
// per cycle through the single store write port; the next beat waits for its end.
// The pixel store read is addressed from the next sequencer state, so bits of the next
// LED are ready without a bubble.
// Reset restores the configuration registers, makes the store read as black through
// valid bits, and leaves the line idle; no clearing pass is needed.
// When o_res is stalled the held result stays put and i_cmd.ready drops, so
// the line only moves when results are taken.
// Registers sit on the APB port at 4*index; writes are meant for idle time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "addressable_led_strip_driver_unit_defines.svh"

module addressable_led_strip_driver_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [aldu_pkg::APB_AW-1:0] paddr,
    input  wire logic [aldu_pkg::APB_DW-1:0] pwdata,
    output logic      [aldu_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    aldu_cmd_if.sink                         i_cmd,
    aldu_res_if.source                       o_res
);
    import aldu_pkg::*;

    t_cfg             cfg;
    t_mem_req         mem_req;
    logic [PIX_W-1:0] rd_data;
    logic             rd_valid;

    // Sequencer and fill state.
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_led, n_led;
    logic [4:0]       r_bit, n_bit;
    logic [15:0]      r_tick, n_tick;
    logic [7:0]       r_rb_phase, n_rb_phase;
    logic             r_walk_busy, n_walk_busy;
    logic [CNT_W-1:0] r_walk_idx, n_walk_idx;
    logic [CNT_W-1:0] r_walk_n, n_walk_n;
    logic [7:0]       r_walk_base, n_walk_base;

    // Output register.
    logic r_out_valid;
    logic r_out_level, r_out_busy, r_out_done, r_out_rej;
    logic n_level, n_busy, n_done, n_rej;

    logic             acc;
    logic [CNT_W-1:0] n_leds;
    logic             bit_one;
    logic [4:0]       bit_sel;
    logic [7:0]       dur_hi;
    logic [7:0]       dur_lo;
    logic [15:0]      dur_rs;
    logic [15:0]      tick_inc;
    logic [CNT_W-1:0] led_inc;
    logic [7:0]       rb_base;
    logic [7:0]       walk_p;

    aldu_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    aldu_pixel_mem u_pixel_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rd_data  (rd_data),
        .o_rd_valid (rd_valid)
    );

    // Handshake: hold off during a fill or while the result is stalled.
    assign i_cmd.ready = !r_walk_busy && (!r_out_valid || o_res.ready);
    assign acc         = i_cmd.valid && i_cmd.ready;

    // Effective LED count, saturated to the store depth.
    assign n_leds = (CMP_W'(cfg.led_count) > CMP_W'(MAX_LEDS)) ?
                    CNT_W'(MAX_LEDS) : CNT_W'(cfg.led_count);

    // Current bit of the LED being sent; the store read is addressed from the next state.
    assign bit_sel = 5'(PIX_W - 1) - r_bit;
    assign bit_one = rd_valid && rd_data[bit_sel];

    // Durations, with zero acting as one tick.
    assign dur_hi   = bit_one ?
                      ((cfg.high1_ticks == 8'd0) ? 8'd1 : cfg.high1_ticks) :
                      ((cfg.high0_ticks == 8'd0) ? 8'd1 : cfg.high0_ticks);
    assign dur_lo   = bit_one ?
                      ((cfg.low1_ticks == 8'd0) ? 8'd1 : cfg.low1_ticks) :
                      ((cfg.low0_ticks == 8'd0) ? 8'd1 : cfg.low0_ticks);
    assign dur_rs   = (cfg.reset_ticks == 16'd0) ? 16'd1 : cfg.reset_ticks;
    assign tick_inc = r_tick + 16'd1;
    assign led_inc  = r_led + CNT_W'(1);
    assign rb_base  = i_cmd.restart_phase ? 8'd0 : r_rb_phase;
    assign walk_p   = r_walk_base + r_walk_idx[7:0];

    // Command decode and line sequencer.
    always_comb begin
        n_phase     = r_phase;
        n_led       = r_led;
        n_bit       = r_bit;
        n_tick      = r_tick;
        n_rb_phase  = r_rb_phase;
        n_walk_busy = r_walk_busy;
        n_walk_idx  = r_walk_idx;
        n_walk_n    = r_walk_n;
        n_walk_base = r_walk_base;
        n_level     = 1'b0;
        n_busy      = 1'b0;
        n_done      = 1'b0;
        n_rej       = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.clr   = 1'b0;
        mem_req.waddr = PIX_AW'(i_cmd.pixel_index);
        mem_req.wdata = {i_cmd.green, i_cmd.red, i_cmd.blue};

        // Rainbow fill, one store entry per cycle.
        if (r_walk_busy) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = PIX_AW'(r_walk_idx);
            mem_req.wdata = wheel_grb(walk_p);
            n_walk_idx    = r_walk_idx + CNT_W'(1);
            if (n_walk_idx == r_walk_n) begin
                n_walk_busy = 1'b0;
            end
        end

        if (acc) begin
            if (t_cmd'(i_cmd.command) == CMD_TICK) begin
                if (r_phase != PH_IDLE) begin
                    n_busy = 1'b1;
                    n_tick = tick_inc;
                    case (r_phase)
                        PH_HIGH: begin
                            n_level = 1'b1;
                            if (tick_inc >= 16'(dur_hi)) begin
                                n_phase = PH_LOW;
                                n_tick  = '0;
                            end
                        end
                        PH_LOW: begin
                            if (tick_inc >= 16'(dur_lo)) begin
                                n_tick = '0;
                                if (r_bit == 5'(PIX_W - 1)) begin
                                    n_bit = '0;
                                    n_led = led_inc;
                                end else begin
                                    n_bit = r_bit + 5'd1;
                                end
                                n_phase = (n_led >= n_leds) ? PH_LATCH : PH_HIGH;
                            end
                        end
                        PH_LATCH: begin
                            if (tick_inc >= dur_rs) begin
                                n_done  = 1'b1;
                                n_phase = PH_IDLE;
                                n_tick  = '0;
                                n_led   = '0;
                                n_bit   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (r_phase != PH_IDLE) begin
                // Frame in flight: everything but tick is turned away.
                n_rej   = 1'b1;
                n_busy  = 1'b1;
                n_level = (r_phase == PH_HIGH);
            end else begin
                case (t_cmd'(i_cmd.command))
                    CMD_WRITE: begin
                        if (CMP_W'(i_cmd.pixel_index) < CMP_W'(n_leds)) begin
                            mem_req.we = 1'b1;
                        end else begin
                            n_rej = 1'b1;
                        end
                    end
                    CMD_CLEAR: begin
                        mem_req.clr = 1'b1;
                    end
                    CMD_START: begin
                        n_led   = '0;
                        n_bit   = '0;
                        n_tick  = '0;
                        n_phase = (n_leds == '0) ? PH_LATCH : PH_HIGH;
                        n_busy  = 1'b1;
                    end
                    CMD_RAINBOW: begin
                        n_rb_phase  = rb_base + 8'd1;
                        n_walk_base = rb_base;
                        n_walk_idx  = '0;
                        n_walk_n    = n_leds;
                        n_walk_busy = (n_leds != '0);
                    end
                    default: begin
                        n_rej = 1'b1;
                    end
                endcase
            end
        end

        // Address from the next state: the data lines up with the next sequencer state.
        mem_req.raddr = (n_led < CNT_W'(MAX_LEDS)) ? PIX_AW'(n_led) : '0;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_led       <= '0;
            r_bit       <= '0;
            r_tick      <= '0;
            r_rb_phase  <= '0;
            r_walk_busy <= 1'b0;
            r_walk_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_led       <= n_led;
            r_bit       <= n_bit;
            r_tick      <= n_tick;
            r_rb_phase  <= n_rb_phase;
            r_walk_busy <= n_walk_busy;
            r_walk_idx  <= n_walk_idx;
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_walk_n    <= n_walk_n;
        r_walk_base <= n_walk_base;
        if (acc) begin
            r_out_level <= n_level;
            r_out_busy  <= n_busy;
            r_out_done  <= n_done;
            r_out_rej   <= n_rej;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.line_level = r_out_level;
    assign o_res.busy_res   = r_out_busy;
    assign o_res.frame_done = r_out_done;
    assign o_res.rejected   = r_out_rej;

    // Checks on the sequencer and fill.
    `ALDU_ASSERT_IMP(a_idle_clean, i_clk, i_rst_n, r_phase == PH_IDLE, r_led == '0 && r_bit == '0 && r_tick == '0)
    `ALDU_ASSERT_IMP(a_bit_range, i_clk, i_rst_n, 1'b1, r_bit < 5'(PIX_W))
    `ALDU_ASSERT_IMP(a_fill_blocks, i_clk, i_rst_n, r_walk_busy, !i_cmd.ready)
    `ALDU_ASSERT_IMP(a_write_idle, i_clk, i_rst_n, mem_req.we || mem_req.clr, r_phase == PH_IDLE)
    `ALDU_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, acc && n_done, r_phase == PH_IDLE && r_out_busy)

endmodule

`default_nettype wire

FILE: src/aldu_cfg_regs.sv
// ----------------------------------------------------------------------------
// LED strip driver configuration registers
// APB-style register file holding LED count and line timing.
// ----------------------------------------------------------------------------
`default_nettype none

module aldu_cfg_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [aldu_pkg::APB_AW-1:0] paddr,
    input  wire logic [aldu_pkg::APB_DW-1:0] pwdata,
    output logic      [aldu_pkg::APB_DW-1:0] prdata,
    output logic                           pready,
    output aldu_pkg::t_cfg                 o_cfg
);
    import aldu_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count   <= RST_LED_COUNT;
            r_cfg.high0_ticks <= RST_HIGH0;
            r_cfg.low0_ticks  <= RST_LOW0;
            r_cfg.high1_ticks <= RST_HIGH1;
            r_cfg.low1_ticks  <= RST_LOW1;
            r_cfg.reset_ticks <= RST_RESET_TICKS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LED_COUNT:   r_cfg.led_count   <= pwdata[8:0];
                REG_HIGH0:       r_cfg.high0_ticks <= pwdata[7:0];
                REG_LOW0:        r_cfg.low0_ticks  <= pwdata[7:0];
                REG_HIGH1:       r_cfg.high1_ticks <= pwdata[7:0];
                REG_LOW1:        r_cfg.low1_ticks  <= pwdata[7:0];
                REG_RESET_TICKS: r_cfg.reset_ticks <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (reg_idx)
            REG_LED_COUNT:   prdata = APB_DW'(r_cfg.led_count);
            REG_HIGH0:       prdata = APB_DW'(r_cfg.high0_ticks);
            REG_LOW0:        prdata = APB_DW'(r_cfg.low0_ticks);
            REG_HIGH1:       prdata = APB_DW'(r_cfg.high1_ticks);
            REG_LOW1:        prdata = APB_DW'(r_cfg.low1_ticks);
            REG_RESET_TICKS: prdata = APB_DW'(r_cfg.reset_ticks);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/aldu_pixel_mem.sv
// ----------------------------------------------------------------------------
// LED strip driver pixel store
// One-write one-read synchronous memory with per-entry valid bits, so that
// a clear drops every entry at once and unwritten entries read as black.
// ----------------------------------------------------------------------------
`default_nettype none

module aldu_pixel_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  aldu_pkg::t_mem_req             i_req,
    output logic      [aldu_pkg::PIX_W-1:0] o_rd_data,
    output logic                           o_rd_valid
);
    import aldu_pkg::*;

    logic [PIX_W-1:0]    mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] r_valid;
    logic [PIX_W-1:0]    r_rd_data;
    logic                r_rd_valid;

    // Data array: write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= mem[i_req.raddr];
    end

    // Valid bits: reset and clear drop all entries to black at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_req.raddr];
            if (i_req.clr) begin
                r_valid <= '0;
            end else if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

endmodule

`default_nettype wire
